// ===== hdl/lvbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lvbr_pkg
// Shared constants, types and helpers of the longest valid bracket run unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lvbr_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int SYM_WIDTH     = 8;
   localparam int LONGEST_WIDTH = 16;

   localparam logic [SYM_WIDTH-1:0] SYM_OPEN_ROUND   = 8'h28;
   localparam logic [SYM_WIDTH-1:0] SYM_CLOSE_ROUND  = 8'h29;
   localparam logic [SYM_WIDTH-1:0] SYM_OPEN_SQUARE  = 8'h5B;
   localparam logic [SYM_WIDTH-1:0] SYM_CLOSE_SQUARE = 8'h5D;
   localparam logic [SYM_WIDTH-1:0] SYM_OPEN_CURLY   = 8'h7B;
   localparam logic [SYM_WIDTH-1:0] SYM_CLOSE_CURLY  = 8'h7D;

   // Operation requested from the stack in one cycle.
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } stack_op_type;

   // Occupancy status reported by the stack.
   typedef struct packed {
      logic empty;
      logic single;
      logic full;
   } stack_status_type;

   function automatic logic is_closer(input logic [SYM_WIDTH-1:0] sym);
      is_closer = (sym == SYM_CLOSE_ROUND) || (sym == SYM_CLOSE_SQUARE) ||
                  (sym == SYM_CLOSE_CURLY);
   endfunction

   // Opener that matches a closing bracket; don't care for other bytes.
   function automatic logic [SYM_WIDTH-1:0] opener_of(input logic [SYM_WIDTH-1:0] sym);
      logic [SYM_WIDTH-1:0] result;
      unique case (sym)
         SYM_CLOSE_ROUND:  result = SYM_OPEN_ROUND;
         SYM_CLOSE_SQUARE: result = SYM_OPEN_SQUARE;
         SYM_CLOSE_CURLY:  result = SYM_OPEN_CURLY;
         default:          result = SYM_OPEN_ROUND;
      endcase
      opener_of = result;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/lvbr_stack.sv =====
// ----------------------------------------------------------------------------
// lvbr_stack
// Bracket stack: a memory for all entries with the top two held in registers,
// so a push or a pop completes in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lvbr_stack #(
   parameter int STACK_DEPTH = lvbr_pkg::STACK_DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = lvbr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lvbr_pkg::stack_op_type              op_i,
   input  logic [lvbr_pkg::SYM_WIDTH-1:0]      push_sym_i,
   input  logic [COUNT_WIDTH-1:0]              push_run_i,
   output lvbr_pkg::stack_status_type          status_o,
   output logic [lvbr_pkg::SYM_WIDTH-1:0]      top_sym_o,
   output logic [COUNT_WIDTH-1:0]              top_run_o,
   output logic [COUNT_WIDTH-1:0]              second_run_o
);

   localparam int ENTRY_WIDTH = lvbr_pkg::SYM_WIDTH + COUNT_WIDTH;
   localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
   localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);

   logic [ENTRY_WIDTH-1:0] mem [STACK_DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;

   logic [CNT_WIDTH-1:0]   count_ff,   count_in;
   logic [ENTRY_WIDTH-1:0] top_ff,     top_in;
   logic [ENTRY_WIDTH-1:0] second_ff,  second_in;
   logic                   sec_mem_ff, sec_mem_in;

   logic [ENTRY_WIDTH-1:0] second_eff;
   logic [ADDR_WIDTH-1:0]  rd_addr;
   logic [ADDR_WIDTH-1:0]  wr_addr;

   // Right after a pop the entry below the new top arrives from the memory
   // read register; otherwise it is held in second_ff.
   assign second_eff = sec_mem_ff ? rd_data_ff : second_ff;
   assign rd_addr    = ADDR_WIDTH'(count_ff - CNT_WIDTH'(3));
   assign wr_addr    = count_ff[ADDR_WIDTH-1:0];

   always_comb begin
      count_in   = count_ff;
      top_in     = top_ff;
      second_in  = second_eff;
      sec_mem_in = 1'b0;
      if (op_i.push) begin
         count_in  = count_ff + CNT_WIDTH'(1);
         top_in    = {push_sym_i, push_run_i};
         second_in = top_ff;
      end else if (op_i.pop) begin
         count_in   = count_ff - CNT_WIDTH'(1);
         top_in     = second_eff;
         sec_mem_in = 1'b1;
      end
      if (op_i.flush) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sec_mem_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sec_mem_ff <= sec_mem_in;
      end
      top_ff    <= top_in;
      second_ff <= second_in;
   end

   always_ff @(posedge clock) begin
      if (op_i.push) begin
         mem[wr_addr] <= {push_sym_i, push_run_i};
      end
      if (op_i.pop) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign status_o.empty  = (count_ff == '0);
   assign status_o.single = (count_ff == CNT_WIDTH'(1));
   assign status_o.full   = (count_ff == CNT_WIDTH'(STACK_DEPTH));

   assign top_sym_o    = top_ff[ENTRY_WIDTH-1:COUNT_WIDTH];
   assign top_run_o    = top_ff[COUNT_WIDTH-1:0];
   assign second_run_o = second_eff[COUNT_WIDTH-1:0];

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_sec_mem_after_pop: assert property (@(posedge clock) disable iff (reset)
      sec_mem_ff |-> $past(op_i.pop))
      else $error("memory read selected without a preceding pop");
`endif

endmodule

`default_nettype wire

// ===== hdl/lvbr_best.sv =====
// ----------------------------------------------------------------------------
// lvbr_best
// Result stage: forms the candidate length, keeps the longest so far and
// holds the result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lvbr_best #(
   parameter int COUNT_WIDTH = lvbr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [COUNT_WIDTH-1:0]                in_run,
   input  logic [COUNT_WIDTH-1:0]                in_base,
   input  logic                                  in_overflow,
   input  logic                                  in_last,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [lvbr_pkg::LONGEST_WIDTH-1:0]    out_longest,
   output logic                                  out_overflow,
   output logic                                  out_last
);

   localparam int WIDE = (COUNT_WIDTH > lvbr_pkg::LONGEST_WIDTH) ?
                         COUNT_WIDTH : lvbr_pkg::LONGEST_WIDTH;

   logic [COUNT_WIDTH-1:0] best_ff,     best_in;
   logic                   valid_ff,    valid_in;
   logic [lvbr_pkg::LONGEST_WIDTH-1:0] longest_ff, longest_in;
   logic                   overflow_ff, overflow_in;
   logic                   last_ff,     last_in;

   logic [COUNT_WIDTH-1:0] cand;
   logic [COUNT_WIDTH-1:0] best_next;
   logic                   take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign cand      = (in_run >= in_base) ? (in_run - in_base) : '0;
   assign best_next = (cand > best_ff) ? cand : best_ff;

   always_comb begin
      best_in     = best_ff;
      valid_in    = valid_ff && !out_ready;
      longest_in  = longest_ff;
      overflow_in = overflow_ff;
      last_in     = last_ff;
      if (take) begin
         valid_in    = 1'b1;
         longest_in  = lvbr_pkg::LONGEST_WIDTH'(WIDE'(best_next));
         overflow_in = in_overflow;
         last_in     = in_last;
         best_in     = in_last ? '0 : best_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         best_ff  <= best_in;
         valid_ff <= valid_in;
      end
      longest_ff  <= longest_in;
      overflow_ff <= overflow_in;
      last_ff     <= last_in;
   end

   assign out_valid    = valid_ff;
   assign out_longest  = longest_ff;
   assign out_overflow = overflow_ff;
   assign out_last     = last_ff;

endmodule

`default_nettype wire

// ===== hdl/longest_valid_bracket_run_unit.sv =====
// A result passes through the s1 register, then the lvbr_best result register.
// Throughput: one symbol per cycle unless the result side holds off; the stack
// keeps its top two entries in registers, so a push or pop never waits on the
// stack memory read port.
// Reset (synchronous): clears the stack count, run, longest, overflow flag
// and both pipeline valid bits; stack memory contents stay as they were.
// ----------------------------------------------------------------------------
// longest_valid_bracket_run_unit
// Tracks the longest well-bracketed run over a stream of symbol bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_valid_bracket_run_unit #(
   parameter int STACK_DEPTH = lvbr_pkg::STACK_DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = lvbr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] longest
   output logic        rsp_tuser,   // [0] overflow
   output logic        rsp_tlast    // done_res
);

   logic [COUNT_WIDTH-1:0] run_ff, run_in;
   logic                   ovf_ff, ovf_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic [COUNT_WIDTH-1:0] s1_run_ff,   s1_run_in;
   logic [COUNT_WIDTH-1:0] s1_base_ff,  s1_base_in;
   logic                   s1_ovf_ff,   s1_ovf_in;
   logic                   s1_last_ff,  s1_last_in;

   lvbr_pkg::stack_op_type     stack_op;
   lvbr_pkg::stack_status_type stack_status;
   logic [lvbr_pkg::SYM_WIDTH-1:0] top_sym;
   logic [COUNT_WIDTH-1:0]         top_run;
   logic [COUNT_WIDTH-1:0]         second_run;

   logic                   s2_ready;
   logic                   in_xfer;
   logic                   closer;
   logic                   match;
   logic [COUNT_WIDTH:0]   run_sum;
   logic [COUNT_WIDTH-1:0] run_plus2;
   logic [COUNT_WIDTH-1:0] run_next;
   logic [COUNT_WIDTH-1:0] base_next;

   assign req_tready = !s1_valid_ff || s2_ready;
   assign in_xfer    = req_tvalid && req_tready;

   assign closer = lvbr_pkg::is_closer(req_tdata);
   assign match  = !stack_status.empty && (top_sym == lvbr_pkg::opener_of(req_tdata));

   // Saturating add of two: a carry out means the sum passed the maximum.
   assign run_sum   = {1'b0, run_ff} + (COUNT_WIDTH + 1)'(2);
   assign run_plus2 = run_sum[COUNT_WIDTH] ? '1 : run_sum[COUNT_WIDTH-1:0];

   always_comb begin
      stack_op       = '0;
      stack_op.push  = in_xfer && !closer && !stack_status.full;
      stack_op.pop   = in_xfer && closer && match;
      stack_op.flush = in_xfer && (req_tlast || (closer && !stack_status.empty && !match));

      run_next  = run_ff;
      base_next = top_run;
      if (closer) begin
         if (match) begin
            run_next  = run_plus2;
            base_next = stack_status.single ? '0 : second_run;
         end else begin
            // Closer on an empty stack or on a mismatched top.
            run_next  = '0;
            base_next = '0;
         end
      end else if (!stack_status.full) begin
         base_next = run_ff;
      end
   end

   always_comb begin
      run_in      = run_ff;
      ovf_in      = ovf_ff;
      s1_valid_in = s1_valid_ff && !s2_ready;
      s1_run_in   = s1_run_ff;
      s1_base_in  = s1_base_ff;
      s1_ovf_in   = s1_ovf_ff;
      s1_last_in  = s1_last_ff;
      if (in_xfer) begin
         s1_valid_in = 1'b1;
         s1_run_in   = run_next;
         s1_base_in  = base_next;
         s1_ovf_in   = ovf_ff || (!closer && stack_status.full);
         s1_last_in  = req_tlast;
         run_in      = req_tlast ? '0 : run_next;
         ovf_in      = req_tlast ? 1'b0 : (ovf_ff || (!closer && stack_status.full));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= '0;
         ovf_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         ovf_ff      <= ovf_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_run_ff  <= s1_run_in;
      s1_base_ff <= s1_base_in;
      s1_ovf_ff  <= s1_ovf_in;
      s1_last_ff <= s1_last_in;
   end

   lvbr_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_stack (
      .clock        (clock),
      .reset        (reset),
      .op_i         (stack_op),
      .push_sym_i   (req_tdata),
      .push_run_i   (run_ff),
      .status_o     (stack_status),
      .top_sym_o    (top_sym),
      .top_run_o    (top_run),
      .second_run_o (second_run)
   );

   lvbr_best #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_best (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_ready     (s2_ready),
      .in_run       (s1_run_ff),
      .in_base      (s1_base_ff),
      .in_overflow  (s1_ovf_ff),
      .in_last      (s1_last_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_longest  (rsp_tdata),
      .out_overflow (rsp_tuser),
      .out_last     (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (in_xfer && req_tlast) |=> (run_ff == '0 && ovf_ff == 1'b0))
      else $error("sequence state not cleared after last transfer");

   a_base_le_run: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_base_ff <= s1_run_ff))
      else $error("saved run above current run");
`endif

endmodule

`default_nettype wire

// ===== sim/longest_valid_bracket_run_unit_test.sv =====
// ----------------------------------------------------------------------------
// longest_valid_bracket_run_unit_test
// Self-checking bench for the longest valid bracket run unit. A queue of
// symbol sequences feeds a stream driver, a bit-accurate predictor computes
// the expected longest run for every accepted transfer, and a monitor checks
// each result transfer against the oldest prediction. Directed sequences cover
// the bracket cases and stack overflow; random well-formed, broken and noisy
// sequences follow under changing backpressure.
// ----------------------------------------------------------------------------

module longest_valid_bracket_run_unit_test;

   localparam int         STACK_SLOTS  = lvbr_pkg::STACK_DEPTH_DEFAULT;
   localparam int         SLOT_BITS    = $clog2(STACK_SLOTS);
   localparam logic [15:0] RUN_LIMIT   = 16'hFFFF;
   localparam int         PHASE_ITEMS  = 320;
   localparam int         LONG_STALL   = 400;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_last;
   } symbol_item_type;

   typedef struct packed {
      logic [15:0] longest;
      logic        overflow;
      logic        done;
   } run_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] symbol
   logic        req_tlast = 1'b0;    // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [15:0] longest
   logic        rsp_tuser;           // [0] overflow
   logic        rsp_tlast;           // done_res

   symbol_item_type pending_symbols[$];
   run_result_type  expected_runs[$];
   int           send_idle_pct = 27;
   int           receive_idle_pct = 49;
   int           error_count = 0;
   int           queued_count = 0;
   logic         stall_trigger = 1'b0;
   logic         stall_seen = 1'b0;
   int           stall_remaining = 0;

   // Predictor state for the open bracket stack and the running counts.
   logic [7:0]  stack_symbols [STACK_SLOTS];
   logic [15:0] stack_saved [STACK_SLOTS];
   logic [6:0]  stack_fill = '0;
   logic [15:0] run_len = '0;
   logic [15:0] best_len = '0;
   logic        overflow_seen = 1'b0;

   longest_valid_bracket_run_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic is_closing_symbol(input logic [7:0] sym);
      return (sym == lvbr_pkg::SYM_CLOSE_ROUND) || (sym == lvbr_pkg::SYM_CLOSE_SQUARE) ||
             (sym == lvbr_pkg::SYM_CLOSE_CURLY);
   endfunction

   function automatic run_result_type predict_longest_run(input logic [7:0] sym,
                                                          input logic is_last);
      logic [7:0]  wanted;
      logic        closing;
      logic [15:0] base;
      logic [15:0] cand;
      run_result_type res;
      closing = 1'b1;
      case (sym)
         lvbr_pkg::SYM_CLOSE_ROUND:  wanted = lvbr_pkg::SYM_OPEN_ROUND;
         lvbr_pkg::SYM_CLOSE_SQUARE: wanted = lvbr_pkg::SYM_OPEN_SQUARE;
         lvbr_pkg::SYM_CLOSE_CURLY:  wanted = lvbr_pkg::SYM_OPEN_CURLY;
         default: begin
            wanted  = 8'h00;
            closing = 1'b0;
         end
      endcase
      if (closing) begin
         if (stack_fill == 0) begin
            run_len = '0;
         end else if (stack_symbols[SLOT_BITS'(stack_fill - 7'd1)] != wanted) begin
            // Any other byte on top, opener or not, breaks the whole run.
            run_len    = '0;
            stack_fill = '0;
         end else begin
            stack_fill = stack_fill - 7'd1;
            run_len    = (run_len > RUN_LIMIT - 16'd2) ? RUN_LIMIT : run_len + 16'd2;
         end
      end else if (stack_fill == STACK_SLOTS) begin
         overflow_seen = 1'b1;
      end else begin
         stack_symbols[SLOT_BITS'(stack_fill)] = sym;
         stack_saved[SLOT_BITS'(stack_fill)]   = run_len;
         stack_fill                            = stack_fill + 7'd1;
      end
      base = (stack_fill != 0) ? stack_saved[SLOT_BITS'(stack_fill - 7'd1)] : 16'd0;
      cand = (run_len >= base) ? run_len - base : 16'd0;
      if (cand > best_len) best_len = cand;
      res.longest  = best_len;
      res.overflow = overflow_seen;
      res.done     = is_last;
      if (is_last) begin
         stack_fill    = '0;
         run_len       = '0;
         best_len      = '0;
         overflow_seen = 1'b0;
      end
      return res;
   endfunction

   // Stream driver: predicts each accepted transfer, then offers the next one.
   always @(posedge clock) begin : drive_symbols
      symbol_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_runs.push_back(predict_longest_run(req_tdata, req_tlast));
         if (!req_tvalid || req_tready) begin
            if (pending_symbols.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               next_item = pending_symbols.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.symbol;
               req_tlast  <= next_item.is_last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side ready, with a long hold-off whenever the trigger toggles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready      <= 1'b0;
         stall_remaining <= 0;
      end else if (stall_trigger != stall_seen) begin
         stall_seen      <= stall_trigger;
         stall_remaining <= LONG_STALL;
         rsp_tready      <= 1'b0;
      end else if (stall_remaining != 0) begin
         stall_remaining <= stall_remaining - 1;
         rsp_tready      <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receive_idle_pct);
      end
   end

   always @(posedge clock) begin : check_runs
      run_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected result transfer longest %0d overflow %0b done %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = expected_runs.pop_front();
            if (rsp_tdata !== want.longest) begin
               $display("%0t: longest mismatch, expected %0d actual %0d",
                        $time, want.longest, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.overflow) begin
               $display("%0t: overflow mismatch, expected %0b actual %0b",
                        $time, want.overflow, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.done) begin
               $display("%0t: done mismatch, expected %0b actual %0b",
                        $time, want.done, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   task automatic queue_symbol(input logic [7:0] sym, input logic is_last);
      symbol_item_type item;
      item.symbol  = sym;
      item.is_last = is_last;
      pending_symbols.push_back(item);
      queued_count++;
   endtask

   task automatic wait_for_drain();
      while (pending_symbols.size() != 0 || req_tvalid || expected_runs.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [7:0] random_opener();
      case ($urandom_range(0, 2))
         0:       return lvbr_pkg::SYM_OPEN_ROUND;
         1:       return lvbr_pkg::SYM_OPEN_SQUARE;
         default: return lvbr_pkg::SYM_OPEN_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] random_closer();
      case ($urandom_range(0, 2))
         0:       return lvbr_pkg::SYM_CLOSE_ROUND;
         1:       return lvbr_pkg::SYM_CLOSE_SQUARE;
         default: return lvbr_pkg::SYM_CLOSE_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] random_pushed_byte();
      logic [7:0] sym;
      do sym = 8'($urandom_range(0, 255)); while (is_closing_symbol(sym));
      return sym;
   endfunction

   function automatic logic [7:0] matching_closer(input logic [7:0] opener);
      case (opener)
         lvbr_pkg::SYM_OPEN_ROUND:  return lvbr_pkg::SYM_CLOSE_ROUND;
         lvbr_pkg::SYM_OPEN_SQUARE: return lvbr_pkg::SYM_CLOSE_SQUARE;
         lvbr_pkg::SYM_OPEN_CURLY:  return lvbr_pkg::SYM_CLOSE_CURLY;
         default:                   return random_closer();
      endcase
   endfunction

   // One sequence: mostly well-formed nesting, some broken, some pure noise.
   task automatic queue_random_sequence();
      logic [7:0] open_symbols[$];
      logic [7:0] sym;
      int         kind;
      int         length;
      kind   = $urandom_range(0, 9);
      length = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 90)
                                             : $urandom_range(1, 30);
      for (int i = 0; i < length; i++) begin
         if (kind == 6 || kind == 7) begin
            case ($urandom_range(0, 2))
               0:       sym = random_opener();
               1:       sym = random_closer();
               default: sym = 8'($urandom_range(0, 255));
            endcase
         end else if (open_symbols.size() != 0 && $urandom_range(0, 1) == 1) begin
            sym = matching_closer(open_symbols.pop_back());
         end else begin
            sym = ($urandom_range(0, 9) == 0) ? random_pushed_byte() : random_opener();
            open_symbols.push_back(sym);
         end
         if (kind >= 8 && $urandom_range(0, 7) == 0) sym = random_closer();
         queue_symbol(sym, i == length - 1);
      end
   endtask

   task automatic run_random_phase();
      int target;
      target = queued_count + PHASE_ITEMS;
      while (queued_count < target) queue_random_sequence();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Matched pairs of each kind, a closer on an empty stack, a closer
      // against another opener, a closer against a plain byte, and the
      // extreme byte values pushed as ordinary symbols.
      queue_symbol(lvbr_pkg::SYM_OPEN_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_SQUARE, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_SQUARE, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_CURLY, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_CURLY, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_SQUARE, 1'b0);
      queue_symbol(8'h61, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_CURLY, 1'b0);
      queue_symbol(8'h00, 1'b0);
      queue_symbol(8'hFF, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_SQUARE, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_SQUARE, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_CURLY, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_CURLY, 1'b1);
      queue_symbol(lvbr_pkg::SYM_CLOSE_SQUARE, 1'b1);

      // Fill the stack past its depth, then unwind it against the top entry.
      for (int i = 0; i < STACK_SLOTS + 2; i++) queue_symbol(lvbr_pkg::SYM_OPEN_ROUND, 1'b0);
      for (int i = 0; i < STACK_SLOTS + 2; i++) queue_symbol(lvbr_pkg::SYM_CLOSE_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_ROUND, 1'b1);
      for (int i = 0; i < STACK_SLOTS + 1; i++) queue_symbol(8'h78, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_SQUARE, 1'b1);
      wait_for_drain();

      run_random_phase();
      // Hold the result side off while the sender keeps offering transfers.
      stall_trigger = ~stall_trigger;
      wait_for_drain();

      send_idle_pct    = 49;
      receive_idle_pct = 27;
      run_random_phase();
      wait_for_drain();

      send_idle_pct    = 0;
      receive_idle_pct = 0;
      run_random_phase();
      queue_symbol(lvbr_pkg::SYM_OPEN_ROUND, 1'b0);
      queue_symbol(lvbr_pkg::SYM_OPEN_SQUARE, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_SQUARE, 1'b0);
      queue_symbol(lvbr_pkg::SYM_CLOSE_ROUND, 1'b1);
      run_random_phase();
      wait_for_drain();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, expected_runs.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lvbr_pkg.sv
hdl/lvbr_stack.sv
hdl/lvbr_best.sv
hdl/longest_valid_bracket_run_unit.sv
sim/longest_valid_bracket_run_unit_test.sv
